[hw/rtl/sti_pkg.sv]
`default_nettype none

package sti_pkg;

  localparam int STI_LIMB_W = 32;
  localparam int STI_MUL_LAT = 3;

  localparam logic [15:0] STI_RADIUS_RESET = 16'd256;
  localparam logic [31:0] STI_R2_RESET = 32'(STI_RADIUS_RESET) * 32'(STI_RADIUS_RESET);

  typedef struct packed {
    logic hit;
    logic near_plane;
    logic degenerate;
  } sti_flags_t;

endpackage

`default_nettype wire

[hw/rtl/sti_mul.sv]
`default_nettype none

module sti_mul
  import sti_pkg::*;
#(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int L   = STI_LIMB_W;
  localparam int NA  = (AW + L - 1) / L;
  localparam int NB  = (BW + L - 1) / L;
  localparam int XW  = NA * L;
  localparam int YW  = NB * L;
  localparam int LPW = 2 * (L + 1);
  localparam int SW  = XW + YW + 2;
  localparam int PW  = AW + BW;

  logic signed [XW-1:0]  a_ext;
  logic signed [YW-1:0]  b_ext;
  logic signed [L:0]     al [NA];
  logic signed [L:0]     bl [NB];
  logic signed [LPW-1:0] pp_r [NA][NB];
  logic signed [SW-1:0]  row_nxt [NA];
  logic signed [SW-1:0]  row_r [NA];
  logic signed [SW-1:0]  sum_nxt;
  logic signed [PW-1:0]  sum_r;

  assign a_ext = XW'(a);
  assign b_ext = YW'(b);

  // split: low limbs unsigned, top limb signed
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        al[i] = {a_ext[XW-1], a_ext[i*L +: L]};
      end else begin
        al[i] = {1'b0, a_ext[i*L +: L]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bl[j] = {b_ext[YW-1], b_ext[j*L +: L]};
      end else begin
        bl[j] = {1'b0, b_ext[j*L +: L]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (SW'(pp_r[i][j]) <<< (j * L));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (row_r[i] <<< (i * L));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= al[i] * bl[j];
        end
        row_r[i] <= row_nxt[i];
      end
      sum_r <= sum_nxt[PW-1:0];
    end
  end

  assign p = sum_r;

endmodule

`default_nettype wire

[hw/rtl/sti_geom.sv]
`default_nettype none

module sti_geom #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_v,
  input  wire logic signed [COORD_BITS-1:0] cen [3],
  input  wire logic signed [COORD_BITS-1:0] va [3],
  input  wire logic signed [COORD_BITS-1:0] vb [3],
  input  wire logic signed [COORD_BITS-1:0] vc [3],
  output logic                              out_v,
  output logic signed [COORD_BITS:0]        w [3],
  output logic signed [2*COORD_BITS+2:0]    n [3],
  output logic signed [2*COORD_BITS+3:0]    d00,
  output logic signed [2*COORD_BITS+3:0]    d01,
  output logic signed [2*COORD_BITS+3:0]    d02,
  output logic signed [2*COORD_BITS+3:0]    d11,
  output logic signed [2*COORD_BITS+3:0]    d12
);

  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int DW = PW + 2;

  logic v1_r, v2_r, v3_r;

  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] w1_r [3];

  logic signed [PW-1:0] c_r [6];
  logic signed [PW-1:0] q00_r [3];
  logic signed [PW-1:0] q01_r [3];
  logic signed [PW-1:0] q02_r [3];
  logic signed [PW-1:0] q11_r [3];
  logic signed [PW-1:0] q12_r [3];
  logic signed [EW-1:0] w2_r [3];

  logic signed [NW-1:0] n_r [3];
  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;
  logic signed [EW-1:0] w3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(vb[i]) - EW'(va[i]);
        e2_r[i] <= EW'(vc[i]) - EW'(va[i]);
        w1_r[i] <= EW'(cen[i]) - EW'(va[i]);
      end

      c_r[0] <= e1_r[1] * e2_r[2];
      c_r[1] <= e1_r[2] * e2_r[1];
      c_r[2] <= e1_r[2] * e2_r[0];
      c_r[3] <= e1_r[0] * e2_r[2];
      c_r[4] <= e1_r[0] * e2_r[1];
      c_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        q00_r[i] <= e2_r[i] * e2_r[i];
        q01_r[i] <= e2_r[i] * e1_r[i];
        q02_r[i] <= e2_r[i] * w1_r[i];
        q11_r[i] <= e1_r[i] * e1_r[i];
        q12_r[i] <= e1_r[i] * w1_r[i];
        w2_r[i]  <= w1_r[i];
      end

      n_r[0] <= NW'(c_r[0]) - NW'(c_r[1]);
      n_r[1] <= NW'(c_r[2]) - NW'(c_r[3]);
      n_r[2] <= NW'(c_r[4]) - NW'(c_r[5]);
      d00_r  <= DW'(q00_r[0]) + DW'(q00_r[1]) + DW'(q00_r[2]);
      d01_r  <= DW'(q01_r[0]) + DW'(q01_r[1]) + DW'(q01_r[2]);
      d02_r  <= DW'(q02_r[0]) + DW'(q02_r[1]) + DW'(q02_r[2]);
      d11_r  <= DW'(q11_r[0]) + DW'(q11_r[1]) + DW'(q11_r[2]);
      d12_r  <= DW'(q12_r[0]) + DW'(q12_r[1]) + DW'(q12_r[2]);
      for (int i = 0; i < 3; i++) begin
        w3_r[i] <= w2_r[i];
      end
    end
  end

  assign out_v = v3_r;
  assign d00   = d00_r;
  assign d01   = d01_r;
  assign d02   = d02_r;
  assign d11   = d11_r;
  assign d12   = d12_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = w3_r[i];
      n[i] = n_r[i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sti_out_buf.sv]
`default_nettype none

module sti_out_buf
  import sti_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire sti_flags_t in_flags,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output sti_flags_t      out_flags
);

  logic       main_v_r, main_v_nxt;
  logic       skid_v_r, skid_v_nxt;
  sti_flags_t main_r, main_nxt;
  sti_flags_t skid_r, skid_nxt;
  logic       push, pop;

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_flags = main_r;

  always_comb begin
    push       = in_valid && !skid_v_r;
    pop        = main_v_r && out_ready;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    priority if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_nxt   = in_flags;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = in_flags;
      end
    end else begin
      if (pop) begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/sphere_triangle_intersect_unit.sv]
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// in_      | input     | in_valid / in_ready     | in_center_*, in_vert_{a,b,c}_* (signed)
// out_     | output    | out_valid / out_ready   | out_hit, out_near_plane, out_degenerate
// cfg_     | input     | cfg_valid / cfg_ready   | cfg_sphere_radius (unsigned 16 bits)
//
// One request per cycle sustained while the output buffer is not full; a taken request
// passes through three geometry stages, two 3-stage limb multipliers in series,
// one sum stage, one compare stage and the output register.
// Reset (rst_n low, synchronous) empties the pipeline and sets the radius to 256.
// A 2-entry output buffer keeps in_ready registered; when it fills, the whole
// pipeline holds until out_ready drains it. cfg_ready is always high.

module sphere_triangle_intersect_unit
  import sti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_center_x,
  input  wire logic signed [COORD_BITS-1:0] in_center_y,
  input  wire logic signed [COORD_BITS-1:0] in_center_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert_a_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert_b_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert_c_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert_c_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert_c_z,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_hit,
  output logic                              out_near_plane,
  output logic                              out_degenerate,

  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [15:0]                  cfg_sphere_radius
);

  localparam int EW  = COORD_BITS + 1;
  localparam int NW  = 2 * EW + 1;
  localparam int DW  = 2 * EW + 2;
  localparam int NNW = 2 * NW + 2;
  localparam int DNW = EW + NW + 2;
  localparam int UW  = 2 * DW + 1;
  localparam int IW  = UW + 2;
  localparam int R2W = 33;
  localparam int LHW = 2 * DNW;
  localparam int RHW = R2W + NNW;
  localparam int CW  = (LHW > RHW ? LHW : RHW) + 1;
  localparam int ML  = STI_MUL_LAT;

  logic en;

  logic [31:0] r2_r;

  logic signed [COORD_BITS-1:0] cen [3];
  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];

  logic                 g_v;
  logic signed [EW-1:0] g_w [3];
  logic signed [NW-1:0] g_n [3];
  logic signed [DW-1:0] g_d00, g_d01, g_d02, g_d11, g_d12;

  logic signed [2*NW-1:0]  p_nn [3];
  logic signed [EW+NW-1:0] p_dn [3];
  logic signed [2*DW-1:0]  p_u0, p_u1, p_v0, p_v1;

  logic [ML-1:0] m1_v_r;
  logic [ML-1:0] m1_deg_r;

  logic                  s4_v_r;
  logic                  s4_deg_r;
  logic signed [NNW-1:0] nn_r;
  logic signed [DNW-1:0] dn_r;
  logic signed [UW-1:0]  un_r;
  logic signed [UW-1:0]  vn_r;

  logic signed [IW-1:0]  in_sum;
  logic                  enclosed;

  logic signed [LHW-1:0] p_lhs;
  logic signed [RHW-1:0] p_rhs;

  logic [ML-1:0] m2_v_r;
  logic [ML-1:0] m2_deg_r;
  logic [ML-1:0] m2_in_r;

  logic       near;
  logic       sf_v_r;
  sti_flags_t sf_flags_r;
  sti_flags_t sf_flags_nxt;
  sti_flags_t ob_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r <= STI_R2_RESET;
    end else if (cfg_valid) begin
      r2_r <= 32'(cfg_sphere_radius) * 32'(cfg_sphere_radius);
    end
  end

  assign cen[0] = in_center_x;
  assign cen[1] = in_center_y;
  assign cen[2] = in_center_z;
  assign va[0]  = in_vert_a_x;
  assign va[1]  = in_vert_a_y;
  assign va[2]  = in_vert_a_z;
  assign vb[0]  = in_vert_b_x;
  assign vb[1]  = in_vert_b_y;
  assign vb[2]  = in_vert_b_z;
  assign vc[0]  = in_vert_c_x;
  assign vc[1]  = in_vert_c_y;
  assign vc[2]  = in_vert_c_z;

  assign in_ready = en;

  sti_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .cen   (cen),
    .va    (va),
    .vb    (vb),
    .vc    (vc),
    .out_v (g_v),
    .w     (g_w),
    .n     (g_n),
    .d00   (g_d00),
    .d01   (g_d01),
    .d02   (g_d02),
    .d11   (g_d11),
    .d12   (g_d12)
  );

  for (genvar k = 0; k < 3; k++) begin : g_mul1
    sti_mul #(.AW(NW), .BW(NW)) u_nn (
      .clk (clk), .en (en), .a (g_n[k]), .b (g_n[k]), .p (p_nn[k])
    );
    sti_mul #(.AW(EW), .BW(NW)) u_dn (
      .clk (clk), .en (en), .a (g_w[k]), .b (g_n[k]), .p (p_dn[k])
    );
  end

  sti_mul #(.AW(DW), .BW(DW)) u_u0 (
    .clk (clk), .en (en), .a (g_d11), .b (g_d02), .p (p_u0)
  );
  sti_mul #(.AW(DW), .BW(DW)) u_u1 (
    .clk (clk), .en (en), .a (g_d01), .b (g_d12), .p (p_u1)
  );
  sti_mul #(.AW(DW), .BW(DW)) u_v0 (
    .clk (clk), .en (en), .a (g_d00), .b (g_d12), .p (p_v0)
  );
  sti_mul #(.AW(DW), .BW(DW)) u_v1 (
    .clk (clk), .en (en), .a (g_d01), .b (g_d02), .p (p_v1)
  );

  // carry valid through both multiplier banks, the sum stage and the compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= '0;
      s4_v_r <= 1'b0;
      m2_v_r <= '0;
      sf_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= {m1_v_r[ML-2:0], g_v};
      s4_v_r <= m1_v_r[ML-1];
      m2_v_r <= {m2_v_r[ML-2:0], s4_v_r};
      sf_v_r <= m2_v_r[ML-1];
    end
  end

  assign in_sum   = IW'(un_r) + IW'(vn_r) - IW'(nn_r);
  assign enclosed = !un_r[UW-1] && !vn_r[UW-1] && in_sum[IW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_deg_r <= {m1_deg_r[ML-2:0], (g_n[0] == '0) && (g_n[1] == '0) && (g_n[2] == '0)};

      s4_deg_r <= m1_deg_r[ML-1];
      nn_r     <= NNW'(p_nn[0]) + NNW'(p_nn[1]) + NNW'(p_nn[2]);
      dn_r     <= DNW'(p_dn[0]) + DNW'(p_dn[1]) + DNW'(p_dn[2]);
      un_r     <= UW'(p_u0) - UW'(p_u1);
      vn_r     <= UW'(p_v0) - UW'(p_v1);

      m2_deg_r <= {m2_deg_r[ML-2:0], s4_deg_r};
      m2_in_r  <= {m2_in_r[ML-2:0], enclosed};

      sf_flags_r <= sf_flags_nxt;
    end
  end

  sti_mul #(.AW(DNW), .BW(DNW)) u_lhs (
    .clk (clk), .en (en), .a (dn_r), .b (dn_r), .p (p_lhs)
  );
  sti_mul #(.AW(R2W), .BW(NNW)) u_rhs (
    .clk (clk), .en (en), .a ($signed({1'b0, r2_r})), .b (nn_r), .p (p_rhs)
  );

  assign near = !m2_deg_r[ML-1] && (CW'(p_lhs) <= CW'(p_rhs));

  always_comb begin
    sf_flags_nxt.degenerate = m2_deg_r[ML-1];
    sf_flags_nxt.near_plane = near;
    sf_flags_nxt.hit        = near && m2_in_r[ML-1];
  end

  sti_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sf_v_r),
    .in_flags  (sf_flags_r),
    .in_ready  (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_flags (ob_flags)
  );

  assign out_hit        = ob_flags.hit;
  assign out_near_plane = ob_flags.near_plane;
  assign out_degenerate = ob_flags.degenerate;

endmodule

`default_nettype wire
